// ===== rtl/tope_pkg.sv =====
`timescale 1ns / 1ps

package tope_pkg;

   localparam int MODE_BUF_LEN = 8;
   localparam int HASH_BYTES   = 20;

   localparam int MODE_W       = 21;
   localparam int DIGITS_W     = 4;
   localparam int HASH_IDX_W   = 5;
   localparam int COUNT_W      = 16;

   localparam int FIFO_DEPTH   = 4;
   localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

   localparam logic [MODE_W-1:0] MODE_BLOB      = 21'o100644;
   localparam logic [MODE_W-1:0] MODE_BLOB_EXEC = 21'o100755;
   localparam logic [MODE_W-1:0] MODE_LINK      = 21'o120000;
   localparam logic [MODE_W-1:0] MODE_TREE      = 21'o040000;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_SEVEN = 8'h37;

   typedef enum logic [2:0] {
      KIND_MODE  = 3'd0,
      KIND_NAME  = 3'd1,
      KIND_HASH  = 3'd2,
      KIND_ERROR = 3'd3,
      KIND_DONE  = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      ERR_TRUNCATED = 2'd0,
      ERR_MODE_LONG = 2'd1,
      ERR_NOT_OCTAL = 2'd2,
      ERR_MODE_BAD  = 2'd3
   } error_type;

   typedef struct packed {
      kind_type               kind;
      logic [15:0]            entry_mode;
      logic                   is_tree;
      logic [7:0]             name_byte;
      logic [6:0]             hex_high;
      logic [6:0]             hex_low;
      logic [HASH_IDX_W-1:0]  hash_index;
      logic                   entry_complete;
      error_type              error_code;
      logic [COUNT_W-1:0]     entry_count;
      logic                   last_of_item;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } result_pair_type;

   function automatic logic [6:0] hex_digit(input logic [3:0] nibble);
      logic [6:0] wide;
      wide = {3'b000, nibble};
      if (nibble < 4'd10) begin
         return 7'h30 + wide;
      end else begin
         return 7'h57 + wide;
      end
   endfunction

endpackage

// ===== rtl/tree_object_entry_parser.sv =====
`timescale 1ns / 1ps

// Tree object entry parser.
// Request channel: one object byte per word (req_data_byte), with
// req_end_of_object set on the final byte of the object.
// Response channel: one result per word; a request word causes zero, one
// or two results, and rsp_last_of_item marks the final one of a request.
// Each byte is parsed in the cycle it is accepted and its results enter a
// four-entry result queue; if the queue was empty, the first result is
// offered on the next cycle, and one byte per cycle is sustained while the
// receiver keeps up. req_ready drops whenever the queue has fewer than two
// free entries, so a stalled receiver throttles the sender and no result
// is ever lost.
// Reset clears the parser state and empties the queue; the block then
// expects the first byte of a new object.
// After a parse error the remaining bytes of the object are dropped without
// results and the final byte restarts the parser.
module tree_object_entry_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_object,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [15:0] rsp_entry_mode,
   output logic        rsp_is_tree,
   output logic [7:0]  rsp_name_byte,
   output logic [6:0]  rsp_hex_high,
   output logic [6:0]  rsp_hex_low,
   output logic [4:0]  rsp_hash_index,
   output logic        rsp_entry_complete,
   output logic [1:0]  rsp_error_code,
   output logic [15:0] rsp_entry_count,
   output logic        rsp_last_of_item
);

   logic                      accept;
   logic                      has_room;
   tope_pkg::result_pair_type results;
   tope_pkg::result_type      head;

   assign req_ready = has_room;
   assign accept    = req_valid && has_room;

   tope_core u_core (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .data_byte     (req_data_byte),
      .end_of_object (req_end_of_object),
      .results       (results)
   );

   tope_rsp_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_en    (accept),
      .push_data  (results),
      .pop        (rsp_ready),
      .head       (head),
      .head_valid (rsp_valid),
      .has_room   (has_room)
   );

   assign rsp_kind           = head.kind;
   assign rsp_entry_mode     = head.entry_mode;
   assign rsp_is_tree        = head.is_tree;
   assign rsp_name_byte      = head.name_byte;
   assign rsp_hex_high       = head.hex_high;
   assign rsp_hex_low        = head.hex_low;
   assign rsp_hash_index     = head.hash_index;
   assign rsp_entry_complete = head.entry_complete;
   assign rsp_error_code     = head.error_code;
   assign rsp_entry_count    = head.entry_count;
   assign rsp_last_of_item   = head.last_of_item;

endmodule

// ===== rtl/tope_core.sv =====
`timescale 1ns / 1ps

module tope_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic [7:0]               data_byte,
   input  logic                     end_of_object,
   output tope_pkg::result_pair_type results
);

   typedef enum logic [1:0] {
      PH_MODE  = 2'd0,
      PH_NAME  = 2'd1,
      PH_HASH  = 2'd2,
      PH_DRAIN = 2'd3
   } phase_type;

   phase_type                         phase_ff, phase_in;
   logic [tope_pkg::MODE_W-1:0]       mode_accum_ff, mode_accum_in;
   logic [tope_pkg::DIGITS_W-1:0]     mode_digits_ff, mode_digits_in;
   logic                              mode_bad_ff, mode_bad_in;
   logic [tope_pkg::HASH_IDX_W-1:0]   hash_pos_ff, hash_pos_in;
   logic [tope_pkg::COUNT_W-1:0]      entries_ff, entries_in;

   tope_pkg::result_type prim;
   tope_pkg::result_type fin;
   logic                 prim_valid;
   logic                 fin_valid;
   logic                 mode_ok;
   logic                 hash_done;

   always_comb begin
      phase_in       = phase_ff;
      mode_accum_in  = mode_accum_ff;
      mode_digits_in = mode_digits_ff;
      mode_bad_in    = mode_bad_ff;
      hash_pos_in    = hash_pos_ff;
      entries_in     = entries_ff;
      prim           = '0;
      fin            = '0;
      prim_valid     = 1'b0;
      fin_valid      = 1'b0;
      results        = '0;

      mode_ok = (mode_accum_ff == tope_pkg::MODE_BLOB) ||
                (mode_accum_ff == tope_pkg::MODE_BLOB_EXEC) ||
                (mode_accum_ff == tope_pkg::MODE_LINK) ||
                (mode_accum_ff == tope_pkg::MODE_TREE);
      hash_done = (({1'b0, hash_pos_ff} + (tope_pkg::HASH_IDX_W + 1)'(1)) >=
                   (tope_pkg::HASH_IDX_W + 1)'(tope_pkg::HASH_BYTES));

      unique case (phase_ff)
         PH_MODE: begin
            if (data_byte == tope_pkg::CHAR_SPACE) begin
               prim_valid = 1'b1;
               if (mode_digits_ff >= tope_pkg::DIGITS_W'(tope_pkg::MODE_BUF_LEN)) begin
                  prim.kind       = tope_pkg::KIND_ERROR;
                  prim.error_code = tope_pkg::ERR_MODE_LONG;
                  phase_in        = PH_DRAIN;
               end else if (mode_bad_ff) begin
                  prim.kind       = tope_pkg::KIND_ERROR;
                  prim.error_code = tope_pkg::ERR_NOT_OCTAL;
                  phase_in        = PH_DRAIN;
               end else if (mode_ok) begin
                  prim.kind       = tope_pkg::KIND_MODE;
                  prim.entry_mode = mode_accum_ff[15:0];
                  prim.is_tree    = (mode_accum_ff == tope_pkg::MODE_TREE);
                  phase_in        = PH_NAME;
               end else begin
                  prim.kind       = tope_pkg::KIND_ERROR;
                  prim.error_code = tope_pkg::ERR_MODE_BAD;
                  phase_in        = PH_DRAIN;
               end
               mode_accum_in  = '0;
               mode_digits_in = '0;
               mode_bad_in    = 1'b0;
            end else begin
               if (data_byte >= tope_pkg::CHAR_ZERO && data_byte <= tope_pkg::CHAR_SEVEN) begin
                  mode_accum_in = {mode_accum_ff[tope_pkg::MODE_W-4:0], data_byte[2:0]};
               end else begin
                  mode_bad_in = 1'b1;
               end
               if (mode_digits_ff != '1) begin
                  mode_digits_in = mode_digits_ff + tope_pkg::DIGITS_W'(1);
               end
            end
         end
         PH_NAME: begin
            if (data_byte == tope_pkg::CHAR_NUL) begin
               phase_in    = PH_HASH;
               hash_pos_in = '0;
            end else begin
               prim_valid     = 1'b1;
               prim.kind      = tope_pkg::KIND_NAME;
               prim.name_byte = data_byte;
            end
         end
         PH_HASH: begin
            prim_valid          = 1'b1;
            prim.kind           = tope_pkg::KIND_HASH;
            prim.name_byte      = data_byte;
            prim.hex_high       = tope_pkg::hex_digit(data_byte[7:4]);
            prim.hex_low        = tope_pkg::hex_digit(data_byte[3:0]);
            prim.hash_index     = hash_pos_ff;
            prim.entry_complete = hash_done;
            if (hash_done) begin
               if (entries_ff != '1) begin
                  entries_in = entries_ff + tope_pkg::COUNT_W'(1);
               end
               phase_in    = PH_MODE;
               hash_pos_in = '0;
            end else begin
               hash_pos_in = hash_pos_ff + tope_pkg::HASH_IDX_W'(1);
            end
         end
         PH_DRAIN: begin
         end
         default: begin
         end
      endcase

      if (end_of_object) begin
         if (phase_ff != PH_DRAIN && phase_in != PH_DRAIN) begin
            fin_valid = 1'b1;
            if (phase_in == PH_MODE && mode_digits_in == '0) begin
               fin.kind        = tope_pkg::KIND_DONE;
               fin.entry_count = entries_in;
            end else begin
               fin.kind       = tope_pkg::KIND_ERROR;
               fin.error_code = tope_pkg::ERR_TRUNCATED;
            end
         end
         phase_in       = PH_MODE;
         mode_accum_in  = '0;
         mode_digits_in = '0;
         mode_bad_in    = 1'b0;
         hash_pos_in    = '0;
         entries_in     = '0;
      end

      fin.last_of_item  = 1'b1;
      prim.last_of_item = !fin_valid;
      if (prim_valid) begin
         results.first  = prim;
         results.second = fin;
         results.count  = fin_valid ? 2'd2 : 2'd1;
      end else begin
         results.first  = fin;
         results.count  = fin_valid ? 2'd1 : 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_MODE;
         mode_accum_ff  <= '0;
         mode_digits_ff <= '0;
         mode_bad_ff    <= 1'b0;
         hash_pos_ff    <= '0;
         entries_ff     <= '0;
      end else if (accept) begin
         phase_ff       <= phase_in;
         mode_accum_ff  <= mode_accum_in;
         mode_digits_ff <= mode_digits_in;
         mode_bad_ff    <= mode_bad_in;
         hash_pos_ff    <= hash_pos_in;
         entries_ff     <= entries_in;
      end
   end

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      accept && end_of_object |=> phase_ff == PH_MODE && entries_ff == '0 &&
                                  mode_digits_ff == '0)
      else $error("object end did not restart the parser");

   a_drain_silent: assert property (@(posedge clock) disable iff (reset)
      accept && phase_ff == PH_DRAIN |-> results.count == 2'd0)
      else $error("word in drain produced a result");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      accept && results.count == 2'd1 |-> results.first.last_of_item)
      else $error("single result not flagged last");

endmodule

// ===== rtl/tope_rsp_fifo.sv =====
`timescale 1ns / 1ps

module tope_rsp_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_en,
   input  tope_pkg::result_pair_type push_data,
   input  logic                      pop,
   output tope_pkg::result_type      head,
   output logic                      head_valid,
   output logic                      has_room
);

   tope_pkg::result_type                entry_ff [tope_pkg::FIFO_DEPTH];
   logic [tope_pkg::FIFO_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [tope_pkg::FIFO_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [tope_pkg::FIFO_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [tope_pkg::FIFO_CNT_W-1:0]     push_cnt;
   logic [tope_pkg::FIFO_PTR_W-1:0]     wr_ptr_next;
   logic                                do_pop;

   assign head       = entry_ff[rd_ptr_ff];
   assign head_valid = (cnt_ff != '0);
   assign has_room   = (cnt_ff <= tope_pkg::FIFO_CNT_W'(tope_pkg::FIFO_DEPTH - 2));
   assign do_pop     = pop && head_valid;
   assign push_cnt   = push_en ? tope_pkg::FIFO_CNT_W'(push_data.count) : '0;
   assign wr_ptr_next = wr_ptr_ff + tope_pkg::FIFO_PTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + tope_pkg::FIFO_PTR_W'(push_cnt);
      rd_ptr_in = do_pop ? rd_ptr_ff + tope_pkg::FIFO_PTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + push_cnt - (do_pop ? tope_pkg::FIFO_CNT_W'(1) : '0);
   end

   always_ff @(posedge clock) begin
      if (push_en && push_data.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push_data.first;
      end
      if (push_en && push_data.count == 2'd2) begin
         entry_ff[wr_ptr_next] <= push_data.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= tope_pkg::FIFO_CNT_W'(tope_pkg::FIFO_DEPTH))
      else $error("result queue overflow");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push_en |-> has_room)
      else $error("word pushed without room for two results");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> wr_ptr_ff - rd_ptr_ff == cnt_ff[tope_pkg::FIFO_PTR_W-1:0])
      else $error("queue pointers and fill count disagree");

endmodule
